// ----- src/lpkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lpkv_pkg
// Shared types and constants for the linear-probing key/value table: table
// geometry, action and status codes, slot layout and controller states.
// ----------------------------------------------------------------------------
package lpkv_pkg;

	// table geometry; the slot count is a power of two so the home slot is
	// the low bits of the hash
	localparam int IDX_W      = 10;
	localparam int TABLE_SIZE = 1 << IDX_W;
	localparam int CNT_W      = IDX_W + 1;
	localparam int LOAD_LIMIT = (TABLE_SIZE * 2) / 3;

	// payload widths
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_NEW  = 2'd0,
		STAT_HIT  = 2'd1,
		STAT_MISS = 2'd2,
		STAT_FULL = 2'd3
	} status_t;

	// one table slot as held in the slot memory
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_RESP
	} state_t;

endpackage

// ----- src/lpkv_ram.sv -----
// ----------------------------------------------------------------------------
// lpkv_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module lpkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/linear_probe_key_value_table_unit.sv -----
// ----------------------------------------------------------------------------
// linear_probe_key_value_table_unit
// Open-addressed key/value table with linear probing, held in one slot RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, key, key_hash, value.
//   Output channel (out_valid/out_ready) returns status and result_value,
//   exactly one result item per input item, in order.
//   Insert and lookup: the item is taken and its home slot read in ST_IDLE,
//   then each slot is examined in ST_PROBE (the slot RAM reads one slot a
//   cycle, the next read issued while the current slot is compared), and
//   the result moves to the output register from ST_RESP. The worst case
//   visits all 1024 slots. Clear rewrites every slot, one a cycle, in
//   ST_CLEAR. An unused action code goes straight to ST_RESP.
//   After reset the block runs a clearing pass over every slot with in_ready
//   low. The output register holds a finished result while out_ready is low;
//   the next item is taken meanwhile and its result waits in the result
//   stage until the output register frees up.
// ----------------------------------------------------------------------------
module linear_probe_key_value_table_unit
	import lpkv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACTION_W-1:0] action,
	input  logic [KEY_W-1:0]    key,
	input  logic [KEY_W-1:0]    key_hash,
	input  logic [VAL_W-1:0]    value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [VAL_W-1:0]    result_value
);

	state_t            state_q, state_d;
	action_t           act_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [IDX_W-1:0]  pos_s1;
	logic [CNT_W-1:0]  probe_cnt_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic [IDX_W-1:0]  sweep_q;
	logic              clr_reply_q;
	status_t           pend_status_q;
	logic [VAL_W-1:0]  pend_value_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [VAL_W-1:0]  result_value_q;

	logic              accept;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [SLOT_W-1:0] rd_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	slot_t             wr_slot;
	slot_t             slot_rd;
	logic              hit;
	logic              empty;
	logic              last;
	logic              probe_done;
	logic              ins_new;
	status_t           done_status;
	logic [VAL_W-1:0]  done_value;
	logic              out_load;
	logic              sweep_last;

	// slot memory
	lpkv_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(TABLE_SIZE)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_slot),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign slot_rd    = slot_t'(rd_data);
	assign accept     = in_valid && in_ready;
	assign sweep_last = (sweep_q == IDX_W'(TABLE_SIZE - 1));

	// slot compare for the probe stage
	assign hit        = slot_rd.valid && (slot_rd.key == key_q);
	assign empty      = !slot_rd.valid;
	assign last       = (probe_cnt_q == CNT_W'(TABLE_SIZE - 1));
	assign probe_done = hit || empty || last;
	assign ins_new    = (act_q == ACT_INSERT) && empty && (entry_count_q < CNT_W'(LOAD_LIMIT));

	// result of a finished probe
	always_comb begin
		if (hit) begin
			done_status = STAT_HIT;
		end else if (act_q == ACT_INSERT) begin
			done_status = ins_new ? STAT_NEW : STAT_FULL;
		end else begin
			done_status = STAT_MISS;
		end
		done_value = hit ? slot_rd.value : '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_last) begin
					state_d = clr_reply_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (action_t'(action))
						ACT_INSERT, ACT_LOOKUP: state_d = ST_PROBE;
						ACT_CLEAR:              state_d = ST_CLEAR;
						default:                state_d = ST_RESP;
					endcase
				end
			end
			ST_PROBE: begin
				if (probe_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls: memory ports, handshake, output load
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		rd_en    = 1'b0;
		rd_addr  = key_hash[IDX_W-1:0];
		wr_en    = 1'b0;
		wr_addr  = pos_s1;
		wr_slot  = '0;
		out_load = (state_q == ST_RESP) && (!out_valid_q || out_ready);
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
			end
			ST_IDLE: begin
				rd_en = accept;
			end
			ST_PROBE: begin
				// read ahead the next slot while the current one is compared
				rd_en         = !probe_done;
				rd_addr       = pos_s1 + IDX_W'(1);
				wr_en         = (act_q == ACT_INSERT) && (hit || ins_new);
				wr_slot.valid = 1'b1;
				wr_slot.key   = key_q;
				wr_slot.value = val_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			sweep_q       <= '0;
			clr_reply_q   <= 1'b0;
			entry_count_q <= '0;
			probe_cnt_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				sweep_q <= sweep_q + IDX_W'(1);
			end
			if (accept) begin
				probe_cnt_q <= '0;
				if (action_t'(action) == ACT_CLEAR) begin
					sweep_q       <= '0;
					clr_reply_q   <= 1'b1;
					entry_count_q <= '0;
				end
			end
			if (state_q == ST_PROBE) begin
				probe_cnt_q <= probe_cnt_q + CNT_W'(1);
				if (ins_new) begin
					entry_count_q <= entry_count_q + CNT_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action_t'(action);
			key_q  <= key;
			val_q  <= value;
			pos_s1 <= key_hash[IDX_W-1:0];
			if (action_t'(action) == ACT_CLEAR) begin
				pend_status_q <= STAT_NEW;
			end else begin
				pend_status_q <= STAT_MISS;
			end
			pend_value_q <= '0;
		end
		if (state_q == ST_PROBE) begin
			pos_s1 <= pos_s1 + IDX_W'(1);
			if (probe_done) begin
				pend_status_q <= done_status;
				pend_value_q  <= done_value;
			end
		end
		if (out_load) begin
			status_q       <= pend_status_q;
			result_value_q <= pend_value_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_value_q;

	// entry count never passes the load limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(LOAD_LIMIT))
		else $error("entry count above load limit");

	// a probe never runs past the whole table
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (probe_cnt_q < CNT_W'(TABLE_SIZE)))
		else $error("probe count out of range");

	// no slot write while waiting for an item or a result slot
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_CLEAR || state_q == ST_PROBE))
		else $error("slot write outside clear or probe");

	// a new insert bumps the entry count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE && ins_new) |=>
		(entry_count_q == $past(entry_count_q) + CNT_W'(1)))
		else $error("entry count not advanced on new insert");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear-probing key/value table. A shadow table
// in the bench tracks every accepted item and works out the status and value
// the block must return. A short table of directed items comes first. Random
// mixed traffic on a clustered key pool follows, then a fill pass that runs
// the table past its load limit, then more mixed traffic. Both handshake
// sides draw random gaps.
// ----------------------------------------------------------------------------
module tb;
	import lpkv_pkg::*;

	localparam int POOL_N       = 40;
	localparam int IDLE_LIMIT   = 6000;
	localparam int DRAIN_CYCLES = 64;
	localparam int N_DIRECTED   = 22;
	localparam logic [KEY_W-1:0] HOME_MASK = KEY_W'(TABLE_SIZE - 1);

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] value;
	} answer_t;

	typedef struct packed {
		action_t          act;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] h;
		logic [VAL_W-1:0] v;
		logic             typed;
		status_t          st;
		logic [VAL_W-1:0] rv;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACTION_W-1:0] action = '0;
	logic [KEY_W-1:0]    key = '0;
	logic [KEY_W-1:0]    key_hash = '0;
	logic [VAL_W-1:0]    value = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    result_value;

	// typed-in expectation travels with the item it belongs to
	logic             row_typed = 1'b0;
	status_t          row_status = STAT_NEW;
	logic [VAL_W-1:0] row_value = '0;

	// shadow copy of the table
	bit               shadow_valid [TABLE_SIZE];
	bit [KEY_W-1:0]   shadow_key   [TABLE_SIZE];
	bit [VAL_W-1:0]   shadow_value [TABLE_SIZE];
	int unsigned      shadow_count = 0;

	answer_t answers_due [$];
	int      error_count = 0;
	int      items_taken = 0;
	int      results_checked = 0;
	int      idle_cycles = 0;
	int      status_seen [4];
	bit      no_idle = 1'b0;

	logic [KEY_W-1:0] pool_key  [POOL_N];
	logic [KEY_W-1:0] pool_hash [POOL_N];
	logic [KEY_W-1:0] fill_keys   [$];
	logic [KEY_W-1:0] fill_hashes [$];
	stim_row_t        directed_rows [N_DIRECTED];

	linear_probe_key_value_table_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.key          (key),
		.key_hash     (key_hash),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_value (result_value)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one item to the shadow table and return the answer it gives
	function automatic answer_t table_apply_item(action_t act, logic [KEY_W-1:0] k,
		logic [KEY_W-1:0] h, logic [VAL_W-1:0] v);
		answer_t     ans;
		int unsigned slot;
		int unsigned n;
		bit          found;
		bit          empty;
		ans.status = STAT_MISS;
		ans.value  = '0;
		slot  = h % TABLE_SIZE;
		found = 1'b0;
		empty = 1'b0;
		// linear probe, bounded by the table size
		for (n = 0; n < TABLE_SIZE && !found && !empty; n++) begin
			if (!shadow_valid[slot])
				empty = 1'b1;
			else if (shadow_key[slot] == k)
				found = 1'b1;
			else
				slot = (slot + 1) % TABLE_SIZE;
		end
		case (act)
			ACT_INSERT: begin
				if (found) begin
					ans.status = STAT_HIT;
					ans.value  = shadow_value[slot];
					shadow_value[slot] = v;
				end else if (!empty || shadow_count + 1 > LOAD_LIMIT) begin
					ans.status = STAT_FULL;
				end else begin
					shadow_valid[slot] = 1'b1;
					shadow_key[slot]   = k;
					shadow_value[slot] = v;
					shadow_count++;
					ans.status = STAT_NEW;
				end
			end
			ACT_LOOKUP: begin
				if (found) begin
					ans.status = STAT_HIT;
					ans.value  = shadow_value[slot];
				end
			end
			ACT_CLEAR: begin
				foreach (shadow_valid[i])
					shadow_valid[i] = 1'b0;
				shadow_count = 0;
				ans.status = STAT_NEW;
			end
			default: ans.status = STAT_MISS;
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input int idx,
		input logic [VAL_W-1:0] got, input logic [VAL_W-1:0] want);
		$display("ERROR at %0t: %s, result %0d: got %0h, expected %0h",
			$realtime, what, idx, got, want);
		error_count++;
	endtask

	// predict on input accept, check on output accept
	always @(posedge clk) begin : monitor
		answer_t ans;
		if (in_valid && in_ready) begin
			ans = table_apply_item(action_t'(action), key, key_hash, value);
			if (row_typed) begin
				ans.status = row_status;
				ans.value  = row_value;
			end
			answers_due.push_back(ans);
			items_taken++;
		end
		if (out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				report_mismatch("result with no item pending", results_checked,
					VAL_W'(status), '0);
			end else begin
				ans = answers_due.pop_front();
				status_seen[ans.status]++;
				if (status !== ans.status)
					report_mismatch("status", results_checked, VAL_W'(status),
						VAL_W'(ans.status));
				if (result_value !== ans.value)
					report_mismatch("result_value", results_checked, result_value,
						ans.value);
			end
			results_checked++;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	// watchdog on cycles without any handshake on either side
	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stall before each result
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// send one item after a random gap; returns at the accepting edge
	task automatic send_item(input action_t act, input logic [KEY_W-1:0] k,
		input logic [KEY_W-1:0] h, input logic [VAL_W-1:0] v,
		input logic typed = 1'b0, input status_t st = STAT_NEW,
		input logic [VAL_W-1:0] rv = '0);
		int gap;
		if ($urandom_range(0, 49) == 0)
			no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		key        <= k;
		key_hash   <= h;
		value      <= v;
		row_typed  <= typed;
		row_status <= st;
		row_value  <= rv;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom();
	endfunction

	// mixed traffic on the clustered pool, plus noise
	task automatic random_mix(input int count);
		int i, r, p, q;
		logic [KEY_W-1:0] h;
		for (i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			p = $urandom_range(0, POOL_N - 1);
			q = $urandom_range(0, POOL_N - 1);
			h = (pool_hash[q] & HOME_MASK) | ($urandom() & ~HOME_MASK);
			if (r < 40)
				send_item(ACT_INSERT, pool_key[p], pool_hash[p], pick_value());
			else if (r < 75)
				send_item(ACT_LOOKUP, pool_key[p], pool_hash[p], $urandom());
			else if (r < 85)
				send_item(r[0] ? ACT_INSERT : ACT_LOOKUP, $urandom(), $urandom(),
					pick_value());
			else if (r < 93)
				send_item(r[0] ? ACT_INSERT : ACT_LOOKUP, pool_key[p], h, pick_value());
			else if (r < 97)
				send_item(ACT_NONE, $urandom(), $urandom(), $urandom());
			else
				send_item(ACT_CLEAR, $urandom(), $urandom(), $urandom());
		end
	endtask

	// run the table past its load limit, with hits and replaces mixed in
	task automatic fill_table();
		int i, r, p;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] h;
		fill_keys.delete();
		fill_hashes.delete();
		send_item(ACT_CLEAR, $urandom(), $urandom(), $urandom());
		for (i = 0; i < LOAD_LIMIT + 40; i++) begin
			r = $urandom_range(0, 99);
			if (r < 20 && fill_keys.size() > 0) begin
				p = $urandom_range(0, fill_keys.size() - 1);
				send_item(r < 10 ? ACT_LOOKUP : ACT_INSERT, fill_keys[p], fill_hashes[p],
					pick_value());
			end else if (r < 23) begin
				send_item(ACT_LOOKUP, $urandom(), $urandom(), $urandom());
			end
			k = $urandom();
			h = $urandom();
			fill_keys.push_back(k);
			fill_hashes.push_back(h);
			send_item(ACT_INSERT, k, h, pick_value());
		end
		// full table: lookups and replaces still work
		for (i = 0; i < 40; i++) begin
			p = $urandom_range(0, fill_keys.size() - 1);
			send_item(i[0] ? ACT_INSERT : ACT_LOOKUP, fill_keys[p], fill_hashes[p],
				pick_value());
		end
	endtask

	// main stimulus
	initial begin
		int i;
		directed_rows = '{
			// lookup on the empty table after reset
			'{ACT_LOOKUP, 32'h0,        32'h0,        32'h0,        1'b1, STAT_MISS, 32'h0},
			// key zero and value zero are ordinary
			'{ACT_INSERT, 32'h0,        32'h0,        32'h0,        1'b1, STAT_NEW,  32'h0},
			'{ACT_LOOKUP, 32'h0,        32'h0,        32'h0,        1'b1, STAT_HIT,  32'h0},
			'{ACT_INSERT, 32'h0,        32'h0,        32'hFFFFFFFF, 1'b1, STAT_HIT,  32'h0},
			'{ACT_LOOKUP, 32'h0,        32'h0,        32'hDEADBEEF, 1'b1, STAT_HIT,
				32'hFFFFFFFF},
			// last slot, then a collision that wraps past slot zero
			'{ACT_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h12345678, 1'b1, STAT_NEW,  32'h0},
			'{ACT_INSERT, 32'hFFFFFFFE, 32'h000003FF, 32'h0,        1'b1, STAT_NEW,  32'h0},
			'{ACT_LOOKUP, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'h0,        1'b0, STAT_NEW,  32'h0},
			'{ACT_INSERT, 32'h5,        32'h00000400, 32'hAAAAAAAA, 1'b0, STAT_NEW,  32'h0},
			'{ACT_LOOKUP, 32'h5,        32'hFFFFFC00, 32'h0,        1'b0, STAT_NEW,  32'h0},
			// miss after walking the chain to an empty slot
			'{ACT_LOOKUP, 32'h6,        32'h0,        32'h0,        1'b1, STAT_MISS, 32'h0},
			'{ACT_LOOKUP, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0,        1'b0, STAT_NEW,  32'h0},
			// unused action code
			'{ACT_NONE,   32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF, 1'b1, STAT_MISS, 32'h0},
			'{ACT_NONE,   32'h55555555, 32'hAAAAAAAA, 32'h0,        1'b1, STAT_MISS, 32'h0},
			'{ACT_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        1'b0, STAT_NEW,  32'h0},
			// clear empties everything
			'{ACT_CLEAR,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, STAT_NEW,  32'h0},
			'{ACT_LOOKUP, 32'h0,        32'h0,        32'h0,        1'b1, STAT_MISS, 32'h0},
			'{ACT_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        1'b1, STAT_MISS, 32'h0},
			// same key, same home slot, different upper hash bits
			'{ACT_INSERT, 32'h80000000, 32'h80000200, 32'h55555555, 1'b1, STAT_NEW,  32'h0},
			'{ACT_INSERT, 32'h80000000, 32'h00000200, 32'hAAAAAAAA, 1'b0, STAT_NEW,  32'h0},
			'{ACT_LOOKUP, 32'h80000000, 32'h80000200, 32'h0,        1'b0, STAT_NEW,  32'h0},
			'{ACT_CLEAR,  32'h0,        32'h0,        32'h0,        1'b1, STAT_NEW,  32'h0}
		};

		// key pool clustered on a few home slots, one cluster at the wrap point
		for (i = 0; i < POOL_N; i++) begin
			pool_key[i] = $urandom();
			case ($urandom_range(0, 3))
				0: pool_hash[i] = KEY_W'((1020 + $urandom_range(0, 7)) % TABLE_SIZE);
				1: pool_hash[i] = KEY_W'(200 + $urandom_range(0, 7));
				2: pool_hash[i] = KEY_W'(513 + $urandom_range(0, 3));
				default: pool_hash[i] = KEY_W'($urandom_range(0, TABLE_SIZE - 1));
			endcase
			pool_hash[i] = pool_hash[i] | ($urandom() & ~HOME_MASK);
		end
		pool_key[0] = '0;
		pool_key[1] = '1;

		// reset, then the block runs its own clearing pass
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[j])
			send_item(directed_rows[j].act, directed_rows[j].k, directed_rows[j].h,
				directed_rows[j].v, directed_rows[j].typed, directed_rows[j].st,
				directed_rows[j].rv);

		random_mix(350);
		fill_table();
		send_item(ACT_CLEAR, $urandom(), $urandom(), $urandom());
		random_mix(150);
		in_valid <= 1'b0;

		// drain
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d items accepted (%0d directed), %0d results checked",
			items_taken, N_DIRECTED, results_checked);
		$display("answers: new/cleared %0d, hit %0d, miss %0d, full %0d",
			status_seen[STAT_NEW], status_seen[STAT_HIT], status_seen[STAT_MISS],
			status_seen[STAT_FULL]);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
